>>> src/single_excitation_config_rank_core_defines.svh
// Assertion helpers for the rank core RTL.
// Both forms sample on clk and are off while rst is high.
`ifndef SINGLE_EXCITATION_CONFIG_RANK_CORE_DEFINES_SVH
`define SINGLE_EXCITATION_CONFIG_RANK_CORE_DEFINES_SVH

// Same-cycle implication.
`define SECR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SECR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/secr_pkg.sv
package secr_pkg;

  localparam int MAX_ELECTRONS = 16;
  localparam int MAX_ORBITALS  = 64;
  localparam int RANK_BITS     = 48;
  localparam int TABLE_DEPTH   = MAX_ELECTRONS * MAX_ORBITALS;

  localparam int TBL_AW  = $clog2(TABLE_DEPTH);
  localparam int LIST_AW = $clog2(MAX_ELECTRONS);
  localparam int CNT_W   = LIST_AW + 1;
  localparam int ORB_W   = 7;
  localparam int VAL_W   = 6;
  localparam int CORE_W  = 6;
  localparam int N_W     = 7;
  localparam int BASE_W  = CNT_W + N_W;
  localparam int ADDR_SW = BASE_W + 1;

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 10;
  localparam int IN_DW   = 80;
  localparam int OUT_DW  = 48;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_LIST  = 2'd0,
    KIND_TABLE = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_ELECTRONS = 2'd0,
    REG_ORBITALS  = 2'd1,
    REG_SPATIAL   = 2'd2,
    REG_CORE      = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_UP,
    S_DOWN,
    S_SEG,
    S_RUN,
    S_DRAIN,
    S_OUT
  } state_t;

  // Request from the sequencer to the rank accumulator.
  typedef struct packed {
    logic                      clear;
    logic                      issue;
    logic signed [ADDR_SW-1:0] addr;
  } rank_req_t;

  // Total orbital number to valence index, modulo 2^VAL_W.
  function automatic logic [VAL_W-1:0] to_valence(input logic [ORB_W-1:0]  orb,
                                                   input logic [N_W-1:0]    spatial,
                                                   input logic [CORE_W-1:0] core);
    logic [ORB_W-1:0] sub;
    logic [ORB_W-1:0] diff;
    sub  = (orb < spatial) ? ORB_W'(core) : ORB_W'({core, 1'b0});
    diff = orb - sub;
    return diff[VAL_W-1:0];
  endfunction

endpackage

>>> src/secr_rank_unit.sv
module secr_rank_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [secr_pkg::TBL_AW-1:0] wr_addr,
  input  logic [secr_pkg::RANK_BITS-1:0] wr_data,
  input  secr_pkg::rank_req_t         req,
  output logic [secr_pkg::RANK_BITS-1:0] acc
);
  import secr_pkg::*;

  logic [RANK_BITS-1:0] tbl_mem [TABLE_DEPTH];
  logic [RANK_BITS-1:0] rd_data;
  logic                 hit_q;
  logic                 in_range;
  logic [RANK_BITS:0]   sum;

  // negative or past-the-end addresses contribute nothing
  assign in_range = req.issue && !req.addr[ADDR_SW-1] &&
                    (req.addr[ADDR_SW-2:0] < (ADDR_SW-1)'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= tbl_mem[req.addr[TBL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= in_range;
    end
  end

  assign sum = {1'b0, acc} + {1'b0, rd_data};

  // saturating accumulate, top value is all ones
  always_ff @(posedge clk) begin
    if (req.clear) begin
      acc <= '0;
    end else if (hit_q) begin
      acc <= sum[RANK_BITS] ? {RANK_BITS{1'b1}} : sum[RANK_BITS-1:0];
    end
  end

endmodule

>>> src/single_excitation_config_rank_core.sv
// Loads (list entry, table word) are accepted while idle; s_axis_tready stays high for them.
// A query maps the list to valence indices, sorts the moved entry into place when the vacated
// orbital is found, walks the segment heads, sums the table terms, then drains and posts the rank.
// One item at a time: the single table read port and accumulator set the pace.
// Reset (rst, synchronous) clears the sequencer, the output valid and the config
// registers to 1,1,1,0; list and table contents are undefined until loaded.
`include "single_excitation_config_rank_core_defines.svh"

module single_excitation_config_rank_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [9:0] slot, [16:10] list_orbital, [64:17] table_word,
  // [71:65] orig_orbital, [78:72] excited_orbital, [79] zero
  input  logic [secr_pkg::IN_DW-1:0]    s_axis_tdata,
  // [1:0] kind
  input  logic [secr_pkg::KIND_W-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [47:0] rank
  output logic [secr_pkg::OUT_DW-1:0]   m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [secr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [secr_pkg::CFG_DW-1:0]   cfg_data
);
  import secr_pkg::*;

  // ---------------- input field unpack ----------------
  kind_t                kind;
  logic [SLOT_W-1:0]    slot;
  logic [ORB_W-1:0]     list_orbital;
  logic [RANK_BITS-1:0] table_word;
  logic [ORB_W-1:0]     orig_orbital;
  logic [ORB_W-1:0]     excited_orbital;

  assign kind            = kind_t'(s_axis_tuser);
  assign slot            = s_axis_tdata[9:0];
  assign list_orbital    = s_axis_tdata[16:10];
  assign table_word      = s_axis_tdata[64:17];
  assign orig_orbital    = s_axis_tdata[71:65];
  assign excited_orbital = s_axis_tdata[78:72];

  // ---------------- configuration registers ----------------
  logic [CNT_W-1:0]  valence_electrons;
  logic [N_W-1:0]    valence_orbitals;
  logic [N_W-1:0]    spatial_orbitals;
  logic [CORE_W-1:0] core_spatial_orbitals;

  always_ff @(posedge clk) begin
    if (rst) begin
      valence_electrons     <= CNT_W'(1);
      valence_orbitals      <= N_W'(1);
      spatial_orbitals      <= N_W'(1);
      core_spatial_orbitals <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ELECTRONS: valence_electrons     <= cfg_data[CNT_W-1:0];
        REG_ORBITALS:  valence_orbitals      <= cfg_data[N_W-1:0];
        REG_SPATIAL:   spatial_orbitals      <= cfg_data[N_W-1:0];
        REG_CORE:      core_spatial_orbitals <= cfg_data[CORE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer state and working registers ----------------
  state_t state, state_next;

  logic [ORB_W-1:0]   ref_orbitals [MAX_ELECTRONS];  // reference list, no reset
  logic [VAL_W-1:0]   work_list    [MAX_ELECTRONS];  // mapped and sorted list

  logic [CNT_W-1:0]   e_lim;      // clamped electron count for this query
  logic [ORB_W-1:0]   orig_q;     // orbital being vacated
  logic [VAL_W-1:0]   mover;      // valence index of the excited orbital
  logic [CNT_W-1:0]   cnt;        // list walk index (map, then segments)
  logic [LIST_AW-1:0] pos;        // current slot of the moving entry
  logic               found;      // orig orbital seen in the list
  logic [VAL_W-1:0]   prev;       // previous list value during the rank walk
  logic [ORB_W-1:0]   n;          // term counter within a segment
  logic [VAL_W-1:0]   hi;         // last term of the segment
  logic [BASE_W-1:0]  base;       // (E - segment) * N

  logic               in_fire;
  logic               query_fire;
  logic [CNT_W-1:0]   e_new;
  logic [ORB_W-1:0]   ref_rd;
  logic               match;
  logic               map_last;
  logic               found_next;
  logic [LIST_AW-1:0] rd_idx;
  logic [VAL_W-1:0]   rd_w;
  logic [CNT_W-1:0]   pos_ext;
  logic               up_move;
  logic               down_move;
  logic [CNT_W-1:0]   cnt_p1;
  logic               seg_last;
  logic [ORB_W-1:0]   lo;
  logic               seg_go;
  logic               run_end;
  logic               out_free;
  rank_req_t          req;
  logic [RANK_BITS-1:0] acc;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign query_fire = in_fire && (kind == KIND_QUERY);
  assign e_new      = (valence_electrons > CNT_W'(MAX_ELECTRONS)) ?
                      CNT_W'(MAX_ELECTRONS) : valence_electrons;

  // map phase: one list entry per cycle
  assign ref_rd     = ref_orbitals[cnt[LIST_AW-1:0]];
  assign match      = (ref_rd == orig_q);
  assign cnt_p1     = cnt + CNT_W'(1);
  assign map_last   = (cnt_p1 == e_lim);
  assign found_next = found || match;

  // single read port on the work list: right neighbor while moving up,
  // left neighbor while moving down, segment head during the rank walk
  always_comb begin
    case (state)
      S_UP:    rd_idx = pos + LIST_AW'(1);
      S_DOWN:  rd_idx = pos - LIST_AW'(1);
      default: rd_idx = cnt[LIST_AW-1:0];
    endcase
  end
  assign rd_w = work_list[rd_idx];

  // sort: the moving value lives in 'mover'; neighbors shift over it,
  // and it is written back once it stops
  assign pos_ext   = CNT_W'(pos);
  assign up_move   = ((pos_ext + CNT_W'(1)) < e_lim) && (mover > rd_w);
  assign down_move = (pos != '0) && (mover < rd_w);

  // rank walk: segment 0 covers n = 1..w[0], segment j covers
  // n = w[j-1]+2..w[j], each term reads word base - n
  assign seg_last = (cnt_p1 == e_lim);
  assign lo       = (cnt == '0) ? ORB_W'(1) : (ORB_W'(prev) + ORB_W'(2));
  assign seg_go   = (lo <= ORB_W'(rd_w));
  assign run_end  = (n == ORB_W'(hi));

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (query_fire) begin
          state_next = (e_new == '0) ? S_DRAIN : S_MAP;
        end
      end
      S_MAP: begin
        if (map_last) begin
          state_next = found_next ? S_UP : S_SEG;
        end
      end
      S_UP: begin
        if (!up_move) begin
          state_next = S_DOWN;
        end
      end
      S_DOWN: begin
        if (!down_move) begin
          state_next = S_SEG;
        end
      end
      S_SEG: begin
        if (seg_go) begin
          state_next = S_RUN;
        end else if (seg_last) begin
          state_next = S_DRAIN;
        end
      end
      S_RUN: begin
        if (run_end) begin
          state_next = seg_last ? S_DRAIN : S_SEG;
        end
      end
      S_DRAIN: state_next = S_OUT;   // last table read lands in the accumulator
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------- sequencer outputs ----------------
  always_comb begin
    s_axis_tready = 1'b0;
    req.clear     = 1'b0;
    req.issue     = 1'b0;
    req.addr      = ADDR_SW'(base) - ADDR_SW'(n);
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        req.clear     = query_fire;
      end
      S_RUN:   req.issue = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- list loads ----------------
  always_ff @(posedge clk) begin
    if (in_fire && (kind == KIND_LIST) && (slot < SLOT_W'(MAX_ELECTRONS))) begin
      ref_orbitals[slot[LIST_AW-1:0]] <= list_orbital;
    end
  end

  // ---------------- work list ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_ELECTRONS; k++) begin
        work_list[k] <= '0;
      end
    end else begin
      case (state)
        S_MAP: begin
          work_list[cnt[LIST_AW-1:0]] <= match ? mover :
              to_valence(ref_rd, spatial_orbitals, core_spatial_orbitals);
        end
        S_UP: begin
          if (up_move) begin
            work_list[pos] <= rd_w;
          end
        end
        S_DOWN: begin
          work_list[pos] <= down_move ? rd_w : mover;
        end
        default: ;
      endcase
    end
  end

  // ---------------- query datapath ----------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (query_fire) begin
          e_lim  <= e_new;
          orig_q <= orig_orbital;
          mover  <= to_valence(excited_orbital, spatial_orbitals, core_spatial_orbitals);
          base   <= BASE_W'(e_new) * BASE_W'(valence_orbitals);
          cnt    <= '0;
        end
      end
      S_MAP: begin
        if (match) begin
          pos <= cnt[LIST_AW-1:0];   // last match wins
        end
        cnt <= map_last ? '0 : cnt_p1;
      end
      S_UP: begin
        if (up_move) begin
          pos <= pos + LIST_AW'(1);
        end
      end
      S_DOWN: begin
        if (down_move) begin
          pos <= pos - LIST_AW'(1);
        end
      end
      S_SEG: begin
        n    <= lo;
        hi   <= rd_w;
        prev <= rd_w;
        if (!seg_go && !seg_last) begin
          cnt  <= cnt_p1;
          base <= base - BASE_W'(valence_orbitals);
        end
      end
      S_RUN: begin
        n <= n + ORB_W'(1);
        if (run_end && !seg_last) begin
          cnt  <= cnt_p1;
          base <= base - BASE_W'(valence_orbitals);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (query_fire) begin
      found <= 1'b0;
    end else if (state == S_MAP) begin
      found <= found_next;
    end
  end

  // ---------------- table and accumulator ----------------
  secr_rank_unit u_rank (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_fire && (kind == KIND_TABLE) && ({1'b0, slot} < (SLOT_W+1)'(TABLE_DEPTH))),
    .wr_addr (slot[TBL_AW-1:0]),
    .wr_data (table_word),
    .req     (req),
    .acc     (acc)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      m_axis_tdata <= acc[OUT_DW-1:0];
    end
  end

  // ---------------- checks ----------------
  logic sort_phase;
  logic pos_ok;
  logic run_ok;
  logic out_load;

  assign sort_phase = (state == S_UP) || (state == S_DOWN);
  assign pos_ok     = (pos_ext < e_lim);
  assign run_ok     = (n <= ORB_W'(hi));
  assign out_load   = (state == S_OUT) && out_free;

  `SECR_ASSERT_NEXT(a_busy_after_query, query_fire, !s_axis_tready, "ready high after query")
  `SECR_ASSERT_NOW(a_pos_in_list, sort_phase, pos_ok, "sort position past list end")
  `SECR_ASSERT_NOW(a_run_bounds, state == S_RUN, run_ok, "term counter past segment end")
  `SECR_ASSERT_NEXT(a_result_posted, out_load, m_axis_tvalid, "result not posted")

endmodule
